// ===== hdl/kct_pkg.sv =====
// Shared types, key codes and digit tables for the keypad countdown timer.
`default_nettype none

package kct_pkg;

  // Timer modes as shown on the mode output
  typedef enum logic [2:0] {
    ModeIdle  = 3'd0,
    ModeEnter = 3'd1,
    ModeRun   = 3'd2,
    ModePause = 3'd3,
    ModeDone  = 3'd4
  } mode_e;

  // Key codes
  localparam logic [3:0] KeyA     = 4'd10;
  localparam logic [3:0] KeyB     = 4'd11;
  localparam logic [3:0] KeyD     = 4'd13;
  localparam logic [3:0] DigitMax = 4'd9;

  // Entry limits
  localparam logic [2:0] TensMax   = 3'd5;
  localparam logic [1:0] MaxDigits = 2'd3;

  // Largest settable time, 9:59
  localparam logic [9:0] MaxSeconds = 10'd599;

  // Status word handed from the control stage to the digit split stage
  typedef struct packed {
    mode_e       mode;
    logic [3:0]  minutes;
    logic [2:0]  tens;
    logic [3:0]  ones;
    logic [1:0]  count;
    logic [9:0]  remaining;
  } status_t;

  // Minutes digit to seconds (times 60), as a small table
  function automatic logic [9:0] min_to_secs(input logic [3:0] m);
    logic [9:0] s;
    case (m)
      4'd0:    s = 10'd0;
      4'd1:    s = 10'd60;
      4'd2:    s = 10'd120;
      4'd3:    s = 10'd180;
      4'd4:    s = 10'd240;
      4'd5:    s = 10'd300;
      4'd6:    s = 10'd360;
      4'd7:    s = 10'd420;
      4'd8:    s = 10'd480;
      4'd9:    s = 10'd540;
      4'd10:   s = 10'd600;
      4'd11:   s = 10'd660;
      4'd12:   s = 10'd720;
      4'd13:   s = 10'd780;
      4'd14:   s = 10'd840;
      default: s = 10'd900;
    endcase
    return s;
  endfunction

  // Tens digit to seconds (times 10)
  function automatic logic [6:0] tens_to_secs(input logic [2:0] t);
    logic [6:0] s;
    case (t)
      3'd0:    s = 7'd0;
      3'd1:    s = 7'd10;
      3'd2:    s = 7'd20;
      3'd3:    s = 7'd30;
      3'd4:    s = 7'd40;
      3'd5:    s = 7'd50;
      3'd6:    s = 7'd60;
      default: s = 7'd70;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/kct_split.sv =====
// Splits the remaining seconds into m:ss digits, or passes the entry digits.
`default_nettype none

module kct_split (
  input  kct_pkg::status_t status_i,
  output logic [3:0]       minutes_o,
  output logic [2:0]       tens_o,
  output logic [3:0]       ones_o
);
  import kct_pkg::*;

  logic [8:0] min_thr;
  logic [4:0] tens_thr;
  logic [3:0] min_cnt;
  logic [5:0] sec_rem;
  logic [2:0] tens_cnt;
  logic [3:0] ones_val;
  logic       show_time;

  // Minutes: count the whole minutes left with parallel compares
  always_comb begin
    for (int k = 1; k <= 9; k++) begin
      min_thr[k-1] = status_i.remaining >= min_to_secs(4'(k));
    end
    min_cnt = 4'($countones(min_thr));
    sec_rem = 6'(status_i.remaining - min_to_secs(min_cnt));
  end

  // Tens and ones of the seconds left over
  always_comb begin
    for (int k = 1; k <= 5; k++) begin
      tens_thr[k-1] = {1'b0, sec_rem} >= tens_to_secs(3'(k));
    end
    tens_cnt = 3'($countones(tens_thr));
    ones_val = 4'({1'b0, sec_rem} - tens_to_secs(tens_cnt));
  end

  // Entry digits in idle and entering, remaining time otherwise
  always_comb begin
    show_time = (status_i.mode == ModeRun) || (status_i.mode == ModePause) ||
                (status_i.mode == ModeDone);
    if (show_time) begin
      minutes_o = min_cnt;
      tens_o    = tens_cnt;
      ones_o    = ones_val;
    end else begin
      minutes_o = status_i.minutes;
      tens_o    = status_i.tens;
      ones_o    = status_i.ones;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/kct_ctrl.sv =====
// Mode state machine, digit entry and elapsed time of the countdown timer.
`default_nettype none

module kct_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             upd_en_i,
  input  logic             func_i,
  input  logic [3:0]       key_i,
  output kct_pkg::status_t status_o
);
  import kct_pkg::*;

  mode_e      mode_q, mode_d;
  logic [3:0] min_q, min_d;
  logic [2:0] tens_q, tens_d;
  logic [3:0] ones_q, ones_d;
  logic [1:0] cnt_q, cnt_d;
  logic [9:0] elap_q, elap_d;
  logic [9:0] tgt_q, tgt_d;
  logic [9:0] tgt_calc;
  logic [9:0] elap_inc;

  // State registers, updated once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      min_q  <= '0;
      tens_q <= '0;
      ones_q <= '0;
      cnt_q  <= '0;
      elap_q <= '0;
      tgt_q  <= '0;
    end else if (upd_en_i) begin
      mode_q <= mode_d;
      min_q  <= min_d;
      tens_q <= tens_d;
      ones_q <= ones_d;
      cnt_q  <= cnt_d;
      elap_q <= elap_d;
      tgt_q  <= tgt_d;
    end
  end

  // Set time from the entered digits
  assign tgt_calc = min_to_secs(min_q) + {3'b000, tens_to_secs(tens_q)} + {6'b0, ones_q};
  // Elapsed never passes the target
  assign elap_inc = (elap_q < tgt_q) ? 10'(elap_q + 10'd1) : elap_q;

  // Next state for a key or a tick
  always_comb begin
    mode_d = mode_q;
    min_d  = min_q;
    tens_d = tens_q;
    ones_d = ones_q;
    cnt_d  = cnt_q;
    elap_d = elap_q;
    tgt_d  = tgt_q;
    if (func_i) begin
      if (mode_q == ModeRun) begin
        elap_d = elap_inc;
        if (elap_inc >= tgt_q) begin
          mode_d = ModeDone;
        end
      end
    end else begin
      unique case (mode_q)
        ModeEnter: begin
          if (key_i == KeyA) begin
            mode_d = ModeRun;
            tgt_d  = tgt_calc;
          end else if (key_i == KeyD) begin
            mode_d = ModeEnter;
            min_d  = '0;
            tens_d = '0;
            ones_d = '0;
            cnt_d  = '0;
            elap_d = '0;
          end else if (key_i <= DigitMax && cnt_q < MaxDigits) begin
            case (cnt_q)
              2'd0:    min_d  = key_i;
              2'd1:    tens_d = (key_i > {1'b0, TensMax}) ? TensMax : key_i[2:0];
              default: ones_d = key_i;
            endcase
            cnt_d = 2'(cnt_q + 2'd1);
          end
        end
        ModeRun: begin
          if (key_i == KeyB) begin
            mode_d = ModePause;
          end
        end
        ModePause: begin
          if (key_i == KeyA) begin
            mode_d = ModeRun;
            tgt_d  = tgt_calc;
          end else if (key_i == KeyD) begin
            mode_d = ModeEnter;
            min_d  = '0;
            tens_d = '0;
            ones_d = '0;
            cnt_d  = '0;
            elap_d = '0;
          end
        end
        default: begin
          // idle, done and unused codes
          if (key_i == KeyD) begin
            mode_d = ModeEnter;
            min_d  = '0;
            tens_d = '0;
            ones_d = '0;
            cnt_d  = '0;
            elap_d = '0;
          end
        end
      endcase
    end
  end

  // Status after this word
  always_comb begin
    status_o.mode    = mode_d;
    status_o.minutes = min_d;
    status_o.tens    = tens_d;
    status_o.ones    = ones_d;
    status_o.count   = cnt_d;
    if ((mode_d == ModeRun || mode_d == ModePause) && tgt_d > elap_d) begin
      status_o.remaining = 10'(tgt_d - elap_d);
    end else begin
      status_o.remaining = '0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/keypad_countdown_timer.sv =====
// A result goes from the input register, through control update and digit split,
//   into the output register. Throughput: one word per cycle while not stalled;
//   each register frees as the next one takes its word.
// Reset (rst_ni low, asynchronous): mode idle, all digits, counts and times zero,
//   both registers empty.
`default_nettype none

module keypad_countdown_timer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       func_i,
  input  logic [3:0] key_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] mode_o,
  output logic [3:0] shown_minutes_o,
  output logic [2:0] shown_tens_o,
  output logic [3:0] shown_ones_o,
  output logic [1:0] entered_count_o,
  output logic [9:0] remaining_seconds_o
);
  import kct_pkg::*;

  logic       s1_v_q, out_v_q;
  logic       s1_rdy, out_rdy;
  logic       s1_func_q;
  logic [3:0] s1_key_q;
  status_t    status_d;
  logic [3:0] split_min;
  logic [2:0] split_tens;
  logic [3:0] split_ones;
  mode_e      out_mode_q;
  logic [3:0] out_min_q, out_ones_q;
  logic [2:0] out_tens_q;
  logic [1:0] out_cnt_q;
  logic [9:0] out_rem_q;

  // Register readiness, back to front
  assign out_rdy    = !out_v_q || out_ready_i;
  assign s1_rdy     = !s1_v_q || out_rdy;
  assign in_ready_o = s1_rdy;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= in_valid_i;
      if (out_rdy) out_v_q <= s1_v_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s1_rdy && in_valid_i) begin
      s1_func_q <= func_i;
      s1_key_q  <= key_i;
    end
    if (out_rdy && s1_v_q) begin
      out_mode_q <= status_d.mode;
      out_min_q  <= split_min;
      out_tens_q <= split_tens;
      out_ones_q <= split_ones;
      out_cnt_q  <= status_d.count;
      out_rem_q  <= status_d.remaining;
    end
  end

  // Control: timer state advances as the word leaves the input register
  kct_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_en_i (s1_v_q && out_rdy),
    .func_i   (s1_func_q),
    .key_i    (s1_key_q),
    .status_o (status_d)
  );

  // Display digits
  kct_split u_split (
    .status_i  (status_d),
    .minutes_o (split_min),
    .tens_o    (split_tens),
    .ones_o    (split_ones)
  );

  assign out_valid_o         = out_v_q;
  assign mode_o              = out_mode_q;
  assign shown_minutes_o     = out_min_q;
  assign shown_tens_o        = out_tens_q;
  assign shown_ones_o        = out_ones_q;
  assign entered_count_o     = out_cnt_q;
  assign remaining_seconds_o = out_rem_q;

endmodule

`default_nettype wire

// ===== hdl/kct_chk.sv =====
// Port-level checks for the keypad countdown timer, bound to the top level.
`default_nettype none

module kct_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] mode_o,
  input logic [3:0] shown_minutes_o,
  input logic [2:0] shown_tens_o,
  input logic [3:0] shown_ones_o,
  input logic [1:0] entered_count_o,
  input logic [9:0] remaining_seconds_o
);
  import kct_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mode_o) &&
      $stable(shown_minutes_o) && $stable(shown_tens_o) && $stable(shown_ones_o) &&
      $stable(remaining_seconds_o))
    else $error("result word changed while stalled");

  // Done shows 0:00 and nothing remaining
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_o == ModeDone |->
      remaining_seconds_o == '0 && shown_minutes_o == '0 && shown_tens_o == '0 &&
      shown_ones_o == '0)
    else $error("done mode with time left");

  // No remaining time during idle or entry
  a_entry_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_o == ModeIdle || mode_o == ModeEnter) |->
      remaining_seconds_o == '0)
    else $error("remaining time outside a count");

  // Display digits and remaining time stay within the settable range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> shown_tens_o <= TensMax && shown_minutes_o <= DigitMax &&
      shown_ones_o <= DigitMax && remaining_seconds_o <= MaxSeconds)
    else $error("display digit out of range");

endmodule

bind keypad_countdown_timer kct_chk u_kct_chk (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .mode_o              (mode_o),
  .shown_minutes_o     (shown_minutes_o),
  .shown_tens_o        (shown_tens_o),
  .shown_ones_o        (shown_ones_o),
  .entered_count_o     (entered_count_o),
  .remaining_seconds_o (remaining_seconds_o)
);

`default_nettype wire
